// ----- src/clwm_pkg.sv -----
// Package: shared types, widths and constants for the CPU load window monitor.
package clwm_pkg;

   localparam int STATE_LANES = 5;
   localparam int EVENTS     = 4;
   localparam int CNT_W      = 32;
   localparam int TICK_W     = 48;
   localparam int PCT_W      = 7;
   localparam int PAGE_W     = 7;
   localparam int TOTAL_W    = 35;
   localparam int PROD_W     = 42;
   localparam int SHARE_DW   = 43;
   localparam int RATE_DW    = 39;
   localparam int TENTHS_W   = 10;
   localparam int ROW_W      = STATE_LANES * CNT_W;

   localparam int ST_USER = 0;
   localparam int ST_SYS  = 2;
   localparam int ST_INTR = 3;
   localparam int ST_IDLE = 4;

   localparam logic [9:0]        SCALE_TENTHS = 10'd1000;
   localparam logic [PAGE_W-1:0] PAGE_RESET   = 7'd4;
   localparam logic [11:0]       ROUND_BIAS   = 12'd5;
   localparam logic [11:0]       RECIP_TEN    = 12'd3277;

   typedef struct packed {
      logic [TICK_W-1:0] tick_now;
      logic [CNT_W-1:0]  user_ticks;
      logic [CNT_W-1:0]  nice_ticks;
      logic [CNT_W-1:0]  system_ticks;
      logic [CNT_W-1:0]  irq_ticks;
      logic [CNT_W-1:0]  idle_ticks;
      logic [CNT_W-1:0]  swap_in_count;
      logic [CNT_W-1:0]  swap_out_count;
      logic [CNT_W-1:0]  irq_count;
      logic [CNT_W-1:0]  switch_count;
   } req_type;

   typedef struct packed {
      logic [PCT_W-1:0] user_pct;
      logic [PCT_W-1:0] system_pct;
      logic [PCT_W-1:0] idle_pct;
      logic [CNT_W-1:0] swap_in_rate;
      logic [CNT_W-1:0] swap_out_rate;
      logic [CNT_W-1:0] irq_rate;
      logic [CNT_W-1:0] switch_rate;
      logic [CNT_W-1:0] raw_system_sum;
      logic             rates_fresh;
   } rsp_type;

   // round tenths half up to whole percent: (t + 5) / 10 by reciprocal
   function automatic logic [PCT_W-1:0] to_whole(input logic [TENTHS_W:0] tenths);
      logic [11:0] biased;
      logic [23:0] prod;
      biased = {1'b0, tenths} + ROUND_BIAS;
      prod   = biased * RECIP_TEN;
      return prod[21:15];
   endfunction

endpackage

// ----- src/clwm_chan_if.sv -----
// Interface: valid/ready channel carrying one payload beat.
interface clwm_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ----- src/cpu_load_window_monitor.sv -----
// Top level: CPU state shares and event rates over a sample window.
// Flow from accepted request beat to response valid: ring read, difference,
//   scale and total, share and rate divider lanes, done check, merge.
// Samples do not overlap: a request beat is taken only in the idle state, so
//   the next request beat can be taken while a response beat still waits.
// Reset: synchronous; ring rows read as zero until written (valid bit per row),
//   held rates and percentages cleared, page size 4 KiB, previous events all ones.
module cpu_load_window_monitor
   import clwm_pkg::*;
#(
   parameter int WINDOW_SAMPLES = 16
) (
   input  logic               clock,
   input  logic               reset,
   clwm_chan_if.sink          req_if,
   clwm_chan_if.source        rsp_if,
   input  logic               csr_we,
   input  logic [PAGE_W-1:0]  csr_wdata
);
   localparam int SW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_SUM   = 6'b000100,
      S_PREP  = 6'b001000,
      S_DIV   = 6'b010000,
      S_MERGE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [PAGE_W-1:0]         page_ff;
   req_type                   req_ff;
   logic [SW-1:0]             slot_ff;
   logic [WINDOW_SAMPLES-1:0] row_valid_ff;
   logic [TICK_W-1:0]         prev_tick_ff;
   logic [CNT_W-1:0]          prev_ev_ff [EVENTS];
   logic [CNT_W-1:0]          held_rate_ff [EVENTS];
   logic [PCT_W-1:0]          held_pct_ff [3];
   logic [CNT_W-1:0]          diff_ff [STATE_LANES];
   logic [CNT_W-1:0]          evd_ff [EVENTS];
   logic [PROD_W-1:0]         prod_ff [STATE_LANES];
   logic [RATE_DW-1:0]        scaled_ff [EVENTS];
   logic [TOTAL_W-1:0]        total_ff;
   logic [TICK_W-1:0]         dt_ff;
   logic                      fresh_ff;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;

   logic [CNT_W-1:0]     cur [STATE_LANES];
   logic [CNT_W-1:0]     ev [EVENTS];
   logic [ROW_W-1:0]     cur_row;
   logic [ROW_W-1:0]     old_row;
   logic [TOTAL_W-1:0]   total_sum;
   logic                 req_take;
   logic                 rsp_free;
   logic                 lane_start;
   logic [SHARE_DW-1:0]  share_q [STATE_LANES];
   logic [RATE_DW-1:0]   rate_q [EVENTS];
   logic [STATE_LANES-1:0] share_busy;
   logic [EVENTS-1:0]    rate_busy;
   logic [TENTHS_W:0]    sys_tenths;

   assign cur[0] = req_ff.user_ticks;
   assign cur[1] = req_ff.nice_ticks;
   assign cur[2] = req_ff.system_ticks;
   assign cur[3] = req_ff.irq_ticks;
   assign cur[4] = req_ff.idle_ticks;
   assign ev[0]  = req_ff.swap_in_count;
   assign ev[1]  = req_ff.swap_out_count;
   assign ev[2]  = req_ff.irq_count;
   assign ev[3]  = req_ff.switch_count;

   always_comb begin
      for (int i = 0; i < STATE_LANES; i++) begin
         cur_row[i*CNT_W +: CNT_W] = cur[i];
      end
      total_sum = '0;
      for (int i = 0; i < STATE_LANES; i++) begin
         total_sum = total_sum + TOTAL_W'(diff_ff[i]);
      end
   end

   assign req_take      = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;
   assign lane_start    = (state_ff == S_PREP);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;
   assign sys_tenths    = {1'b0, share_q[ST_SYS][TENTHS_W-1:0]} +
                          {1'b0, share_q[ST_INTR][TENTHS_W-1:0]};

   clwm_ram #(.WIDTH(ROW_W), .DEPTH(WINDOW_SAMPLES)) u_ring (
      .clock (clock),
      .we    (state_ff == S_READ),
      .waddr (slot_ff),
      .wdata (cur_row),
      .re    (req_take),
      .raddr (slot_ff),
      .rdata (old_row)
   );

   for (genvar g = 0; g < STATE_LANES; g++) begin : g_share
      clwm_div_lane #(.DW(SHARE_DW), .VW(TOTAL_W)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .start    (lane_start),
         .dividend ({1'b0, prod_ff[g]} + SHARE_DW'(total_ff[TOTAL_W-1:1])),
         .divisor  (total_ff),
         .busy     (share_busy[g]),
         .quotient (share_q[g])
      );
   end

   for (genvar g = 0; g < EVENTS; g++) begin : g_rate
      clwm_div_lane #(.DW(RATE_DW), .VW(TICK_W)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .start    (lane_start),
         .dividend (scaled_ff[g]),
         .divisor  (dt_ff),
         .busy     (rate_busy[g]),
         .quotient (rate_q[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_take) state_in = S_READ;
         S_READ:  state_in = S_SUM;
         S_SUM:   state_in = S_PREP;
         S_PREP:  state_in = S_DIV;
         S_DIV:   if (share_busy == '0 && rate_busy == '0) state_in = S_MERGE;
         S_MERGE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         page_ff      <= PAGE_RESET;
         slot_ff      <= '0;
         row_valid_ff <= '0;
         prev_tick_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < EVENTS; i++) begin
            prev_ev_ff[i]   <= '1;
            held_rate_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            held_pct_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            page_ff <= csr_wdata;
         end
         if (state_ff == S_MERGE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_READ) begin
            row_valid_ff[slot_ff] <= 1'b1;
            slot_ff      <= (slot_ff == SW'(WINDOW_SAMPLES - 1)) ? '0 : slot_ff + SW'(1);
            prev_tick_ff <= req_ff.tick_now;
            for (int i = 0; i < EVENTS; i++) begin
               prev_ev_ff[i] <= ev[i];
            end
         end
         if (state_ff == S_MERGE && rsp_free && fresh_ff) begin
            for (int i = 0; i < EVENTS; i++) begin
               held_rate_ff[i] <= rate_q[i][CNT_W-1:0];
            end
            held_pct_ff[0] <= to_whole({1'b0, share_q[ST_USER][TENTHS_W-1:0]});
            held_pct_ff[1] <= to_whole(sys_tenths);
            held_pct_ff[2] <= to_whole({1'b0, share_q[ST_IDLE][TENTHS_W-1:0]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_if.payload;
      end
      if (state_ff == S_READ) begin
         for (int i = 0; i < STATE_LANES; i++) begin
            diff_ff[i] <= cur[i] -
               (row_valid_ff[slot_ff] ? old_row[i*CNT_W +: CNT_W] : '0);
         end
         for (int i = 0; i < EVENTS; i++) begin
            evd_ff[i] <= ev[i] - prev_ev_ff[i];
         end
         fresh_ff <= (prev_tick_ff != '0) && (req_ff.tick_now > prev_tick_ff);
         dt_ff    <= req_ff.tick_now - prev_tick_ff;
      end
      if (state_ff == S_SUM) begin
         total_ff <= (total_sum == '0) ? TOTAL_W'(1) : total_sum;
         for (int i = 0; i < STATE_LANES; i++) begin
            prod_ff[i] <= PROD_W'(diff_ff[i] * SCALE_TENTHS);
         end
         for (int i = 0; i < EVENTS; i++) begin
            if (i < 2) begin
               scaled_ff[i] <= RATE_DW'(evd_ff[i] * page_ff);
            end else begin
               scaled_ff[i] <= RATE_DW'(evd_ff[i]);
            end
         end
      end
      if (state_ff == S_MERGE && rsp_free) begin
         rsp_ff.raw_system_sum <= req_ff.system_ticks + req_ff.irq_ticks;
         rsp_ff.rates_fresh    <= fresh_ff;
         if (fresh_ff) begin
            rsp_ff.user_pct      <= to_whole({1'b0, share_q[ST_USER][TENTHS_W-1:0]});
            rsp_ff.system_pct    <= to_whole(sys_tenths);
            rsp_ff.idle_pct      <= to_whole({1'b0, share_q[ST_IDLE][TENTHS_W-1:0]});
            rsp_ff.swap_in_rate  <= rate_q[0][CNT_W-1:0];
            rsp_ff.swap_out_rate <= rate_q[1][CNT_W-1:0];
            rsp_ff.irq_rate      <= rate_q[2][CNT_W-1:0];
            rsp_ff.switch_rate   <= rate_q[3][CNT_W-1:0];
         end else begin
            rsp_ff.user_pct      <= held_pct_ff[0];
            rsp_ff.system_pct    <= held_pct_ff[1];
            rsp_ff.idle_pct      <= held_pct_ff[2];
            rsp_ff.swap_in_rate  <= held_rate_ff[0];
            rsp_ff.swap_out_rate <= held_rate_ff[1];
            rsp_ff.irq_rate      <= held_rate_ff[2];
            rsp_ff.switch_rate   <= held_rate_ff[3];
         end
      end
   end
endmodule

// ----- src/clwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module clwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- src/clwm_div_lane.sv -----
// Divider lane: restoring division, one quotient bit per cycle.
module clwm_div_lane #(
   parameter int DW = 43,
   parameter int VW = 35
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] div_ff, div_in;
   logic [VW:0]   shifted;
   logic [VW:0]   trial;
   logic          fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      trial   = shifted - {1'b0, div_ff};
      fits    = (shifted >= {1'b0, div_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[VW-1:0] : shifted[VW-1:0];
         quo_in  = {quo_ff[DW-2:0], fits};
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

// ----- tb/tb_chan_if.sv -----
// Testbench-side note: channel interface comes from the RTL; this file holds the model state package.
`timescale 1ns / 100ps
package tb_clwm_pkg;
   import clwm_pkg::*;

   typedef struct {
      logic [CNT_W-1:0]  ring [16][STATE_LANES];
      int unsigned       slot;
      logic [TICK_W-1:0] last_tick;
      logic [CNT_W-1:0]  last_events [EVENTS];
      logic [CNT_W-1:0]  rates [EVENTS];
      logic [PCT_W-1:0]  pcts [3];
      logic [PAGE_W-1:0] page_kb;
   } monitor_state_type;
endpackage

// ----- tb/tb.sv -----
// Testbench top: drives samples, predicts CPU shares and event rates, checks responses.
`timescale 1ns / 100ps
module tb;
   import clwm_pkg::*;
   import tb_clwm_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [PAGE_W-1:0] csr_wdata = '0;
   int errors = 0;
   int hold_off = 0;
   int tx_gap = 0;
   int rx_gap = 0;
   bit feeding = 0;
   bit req_taken = 0;

   clwm_chan_if #(.payload_type(req_type)) req_if ();
   clwm_chan_if #(.payload_type(rsp_type)) rsp_if ();

   cpu_load_window_monitor dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   monitor_state_type model;
   req_type pending_samples[$];
   rsp_type expected_loads[$];

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("cpu_load_window_monitor test failed");
      $finish;
   end

   function automatic logic [PCT_W-1:0] round_whole(input logic [31:0] t);
      return PCT_W'((t / 10) + ((t % 10) >= 5 ? 1 : 0));
   endfunction

   function automatic rsp_type predict_load(input req_type s);
      rsp_type r;
      logic [CNT_W-1:0] cur[STATE_LANES], diff[STATE_LANES], ev[EVENTS];
      logic [31:0] tenths[STATE_LANES];
      logic [63:0] total, dt, d;
      logic [CNT_W-1:0] dev;
      bit fresh;
      cur = '{s.user_ticks, s.nice_ticks, s.system_ticks, s.irq_ticks, s.idle_ticks};
      ev = '{s.swap_in_count, s.swap_out_count, s.irq_count, s.switch_count};
      total = 0;
      for (int i = 0; i < STATE_LANES; i++) begin
         diff[i] = cur[i] - model.ring[model.slot][i];
         total += diff[i];
         model.ring[model.slot][i] = cur[i];
      end
      if (total == 0) total = 1;
      for (int i = 0; i < STATE_LANES; i++)
         tenths[i] = 32'((64'(diff[i]) * 1000 + total / 2) / total);
      fresh = model.last_tick != 0 && s.tick_now > model.last_tick;
      if (fresh) begin
         dt = 64'(s.tick_now - model.last_tick);
         for (int i = 0; i < EVENTS; i++) begin
            dev = ev[i] - model.last_events[i];
            d = 64'(dev);
            if (i < 2) d = d * model.page_kb;
            model.rates[i] = CNT_W'(d / dt);
         end
         model.pcts[0] = round_whole(tenths[ST_USER]);
         model.pcts[1] = round_whole(tenths[ST_SYS] + tenths[ST_INTR]);
         model.pcts[2] = round_whole(tenths[ST_IDLE]);
      end
      model.last_events = ev;
      model.last_tick = s.tick_now;
      model.slot = (model.slot + 1) % 16;
      r.user_pct = model.pcts[0];
      r.system_pct = model.pcts[1];
      r.idle_pct = model.pcts[2];
      r.swap_in_rate = model.rates[0];
      r.swap_out_rate = model.rates[1];
      r.irq_rate = model.rates[2];
      r.switch_rate = model.rates[3];
      r.raw_system_sum = s.system_ticks + s.irq_ticks;
      r.rates_fresh = fresh;
      return r;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(9) < 5) return 0;
      if ($urandom_range(9) < 8) return $urandom_range(3);
      return $urandom_range(60);
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 0;
      end else if (req_if.valid && !req_taken) begin
      end else begin
         if (req_taken) tx_gap = pick_gap();
         if (tx_gap > 0 || !feeding || pending_samples.size() == 0) begin
            if (tx_gap > 0) tx_gap--;
            req_if.valid <= 0;
         end else begin
            req_if.payload <= pending_samples.pop_front();
            req_if.valid <= 1;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_if.ready <= 0;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_if.ready <= 0;
      end else begin
         rsp_if.ready <= 1;
         rx_gap = pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      req_taken = !reset && req_if.valid && req_if.ready;
      if (req_taken)
         expected_loads.push_back(predict_load(req_if.payload));
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_loads.size() == 0) begin
            $display("%0t: unexpected beat %p", $realtime, rsp_if.payload);
            errors++;
         end else begin
            rsp_type e;
            e = expected_loads.pop_front();
            if (rsp_if.payload !== e) begin
               $display("%0t: mismatch expected %p actual %p", $realtime, e,
                        rsp_if.payload);
               errors++;
            end
         end
      end
   end

   logic [TICK_W-1:0] tick_base;
   logic [CNT_W-1:0] ctr[9];

   task automatic push_sample(input logic [TICK_W-1:0] t, input bit jump);
      req_type s;
      for (int i = 0; i < 9; i++) begin
         if (jump) ctr[i] = $urandom;
         else ctr[i] += ($urandom_range(3) == 0) ? $urandom : $urandom_range(500);
      end
      s = '{t, ctr[0], ctr[1], ctr[2], ctr[3], ctr[4], ctr[5], ctr[6], ctr[7], ctr[8]};
      pending_samples.push_back(s);
   endtask

   task automatic run_phase();
      feeding = 1;
      wait (pending_samples.size() == 0 && !req_if.valid);
      wait (expected_loads.size() == 0);
      feeding = 0;
      repeat (100) @(posedge clock);
   endtask

   task automatic write_page(input logic [PAGE_W-1:0] v);
      @(negedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      model.page_kb = v;
   endtask

   initial begin
      logic [PAGE_W-1:0] pages[5] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd4};
      req_type s;
      req_if.valid = 0;
      req_if.payload = '0;
      rsp_if.ready = 0;
      foreach (model.ring[i, j]) model.ring[i][j] = '0;
      model.slot = 0;
      model.last_tick = '0;
      foreach (model.last_events[i]) model.last_events[i] = '1;
      foreach (model.rates[i]) model.rates[i] = '0;
      foreach (model.pcts[i]) model.pcts[i] = '0;
      model.page_kb = 4;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: zero tick, zero deltas, all ones, wraps, stalled tick
      pending_samples.push_back('0);
      pending_samples.push_back('0);
      s = '1;
      pending_samples.push_back(s);
      s.tick_now = '1;
      s.user_ticks = 0;
      pending_samples.push_back(s);
      s = '{48'd5, 1, 2, 3, 4, 5, 6, 7, 8, 9};
      pending_samples.push_back(s);
      pending_samples.push_back(s);
      s.tick_now = 48'd6;
      s.idle_ticks = 32'd1000;
      pending_samples.push_back(s);
      s.tick_now = 48'd3;
      pending_samples.push_back(s);
      s = '{48'h800000000000, 32'h80000000, 0, 32'h7fffffff, 32'h1, 0, 32'h3, 0,
            32'hffffffff, 32'h55555555};
      pending_samples.push_back(s);
      s.tick_now = s.tick_now + 1;
      s.user_ticks = 32'h00000005;
      pending_samples.push_back(s);
      run_phase();
      foreach (pages[p]) begin
         write_page(pages[p]);
         tick_base = TICK_W'($urandom_range(1000) + 1);
         foreach (ctr[i]) ctr[i] = $urandom;
         for (int n = 0; n < 120; n++) begin
            case ($urandom_range(19))
               0: push_sample(tick_base - $urandom_range(5), 0);
               1: push_sample(TICK_W'({$urandom, $urandom}), 1);
               2: push_sample(48'd0, 0);
               default: begin
                  tick_base += ($urandom_range(4) == 0) ? $urandom : $urandom_range(300) + 1;
                  push_sample(tick_base, 0);
               end
            endcase
         end
         if (p == 1) begin
            hold_off = 2000;
         end
         run_phase();
      end
      if (errors == 0) begin
         $display("cpu_load_window_monitor test passed");
      end else begin
         $display("cpu_load_window_monitor test failed");
      end
      $finish;
   end
endmodule
